### src/oilt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oilt_pkg
// Types and fixed constants shared by the ordered id list table.
// ---------------------------------------------------------------------------
package oilt_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned SLOT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] key_id;
    logic [ID_W-1:0] new_id;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new request
    logic search; // compare all cells, register match vector
    logic apply;  // edit the table and load the result register
  } cmd_t;

endpackage

### src/oilt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oilt_ctrl
// Sequencer: idle, search, apply; owns both handshakes.
// ---------------------------------------------------------------------------
module oilt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output oilt_pkg::cmd_t cmd
);
  import oilt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       take;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || ((state == ST_APPLY) && out_free);
  assign take     = in_valid && in_ready;

  assign cmd.load   = take;
  assign cmd.search = (state == ST_SEARCH);
  assign cmd.apply  = (state == ST_APPLY) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) state_next = take ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.apply) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### src/oilt_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oilt_dp
// Table cells, parallel compare, first-match pick, shift edit, result register.
// ---------------------------------------------------------------------------
module oilt_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  oilt_pkg::cmd_t  cmd,
  input  oilt_pkg::in_t   in_data,
  output oilt_pkg::out_t  out_data
);
  import oilt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  logic [OP_W-1:0]        op_q;
  logic [ID_W-1:0]        key_q;
  logic [ID_W-1:0]        nid_q;
  logic [ID_W-1:0]        id_table [TABLE_DEPTH];
  logic [ID_W-1:0]        table_next [TABLE_DEPTH];
  logic [ID_W-1:0]        prev_id [TABLE_DEPTH];
  logic [ID_W-1:0]        succ_id [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] first_hot;
  logic [TABLE_DEPTH-1:0] below;
  logic [TABLE_DEPTH-1:0] after_first;
  logic [ID_W-1:0]        target;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W:0]         slot_wide;
  logic                   found;
  logic                   hit;

  // Neighbor taps for the shifts
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign prev_id[g] = '0;
    end else begin : g_prev
      assign prev_id[g] = id_table[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign succ_id[g] = '0;
    end else begin : g_succ
      assign succ_id[g] = id_table[g+1];
    end
  end

  // Append searches for the first empty slot
  assign target = (op_q == OP_APPEND) ? '0 : key_q;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_vec[i] = (id_table[i] == target);
    end
  end

  // Isolate first match, mark cells below it and the cell right after it
  assign first_hot   = match & (~match + TABLE_DEPTH'(1));
  assign below       = first_hot - TABLE_DEPTH'(1);
  assign after_first = first_hot << 1;
  assign found       = |match;

  always_comb begin
    idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_hot[i]) idx = idx | IDX_W'(i);
    end
  end

  always_comb begin
    hit       = 1'b0;
    slot_wide = '0;
    case (op_q)
      OP_APPEND, OP_UPDATE, OP_REMOVE: begin
        hit       = found;
        slot_wide = {1'b0, idx};
      end
      OP_INSERT: begin
        hit       = found && !first_hot[TABLE_DEPTH-1];
        slot_wide = {1'b0, idx} + (IDX_W+1)'(1);
      end
      OP_CLEAR: begin
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (!hit) slot_wide = '0;
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      table_next[i] = id_table[i];
      case (op_q)
        OP_APPEND, OP_UPDATE: begin
          if (first_hot[i]) table_next[i] = nid_q;
        end
        OP_INSERT: begin
          if (after_first[i]) table_next[i] = nid_q;
          else if (!below[i] && !first_hot[i]) table_next[i] = prev_id[i];
        end
        OP_REMOVE: begin
          if (!below[i]) table_next[i] = succ_id[i];
        end
        OP_CLEAR: begin
          table_next[i] = '0;
        end
        default: begin
          table_next[i] = id_table[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_data.op;
      key_q <= in_data.key_id;
      nid_q <= in_data.new_id;
    end
    if (cmd.search) match <= match_vec;
    if (cmd.apply) begin
      out_data.hit  <= hit;
      out_data.slot <= SLOT_W'(slot_wide);
    end
  end

  // Table starts empty
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) id_table[i] <= '0;
    end else if (cmd.apply && hit) begin
      for (int i = 0; i < TABLE_DEPTH; i++) id_table[i] <= table_next[i];
    end
  end

endmodule

### src/ordered_id_list_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_id_list_table_top
// Ordered table of 16-bit ids with append, insert, remove, update and clear.
// ---------------------------------------------------------------------------
// The input transfer captures a request. In the search step every cell is
// compared against the key in parallel and the match vector is registered;
// in the apply step the first match is picked, the shift edit is applied to
// the table and the result register is loaded and marked valid. The next
// request can be taken during the apply step, but not during the search
// step; the table edit waits for the result register to drain when the
// output side stalls. Zero marks an empty slot; the table is empty after
// reset. The result slot is reported modulo 32.
// ---------------------------------------------------------------------------
module ordered_id_list_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  oilt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output oilt_pkg::out_t out_data
);
  import oilt_pkg::*;

  cmd_t cmd;

  // Sequencer: decides when to capture, search and apply
  oilt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Table cells and edit logic
  oilt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered id list table.
// ---------------------------------------------------------------------------
// A directed table of edits walks the table through its corner cases: misses
// on an empty table, key zero, new id zero, a full table, and an insert after
// the last slot. Random edits follow, mostly aimed at ids that are really in
// the table. A local shadow table predicts each result not typed by hand, and
// each output transfer is checked field by field against the oldest one owed.
// Random stalls on both sides run in three phases of different pressure.
// ---------------------------------------------------------------------------
module tb;
  import oilt_pkg::*;

  localparam int DEPTH        = 32;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_EDITS = 400;   // per phase, three phases
  localparam int TAIL_CYCLES  = 10;

  // Op codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // One row of the directed table. A row repeats rep times with new_id
  // counting up; typed rows carry a result that is read off by hand.
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   key_id;
    logic [ID_W-1:0]   new_id;
    int                rep;
    bit                typed;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } edit_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Hand-written result for the edit now on the input, if any
  bit   typed_now = 1'b0;
  out_t typed_result = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Shadow copy of the table and the results still owed by the block
  logic [ID_W-1:0] shadow_ids [DEPTH];
  out_t            owed_results [$];
  edit_row_t       directed_edits [$];

  int n_fail = 0;
  int n_edits = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_full_appends = 0;
  int n_last_inserts = 0;
  int n_per_op [8];
  int stall_cycles = 0;

  ordered_id_list_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // First slot holding val, DEPTH when none does
  function automatic int first_slot(logic [ID_W-1:0] val);
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_ids[i] == val) return i;
    end
    return DEPTH;
  endfunction

  // Apply one edit to the shadow table and return the result it must give
  function automatic out_t edit_table(in_t e);
    out_t r;
    int   idx;
    int   i;
    r = '0;
    case (e.op)
      OP_APPEND: begin
        idx = first_slot('0);
        if (idx < DEPTH) begin
          shadow_ids[idx] = e.new_id;
          r.hit  = 1'b1;
          r.slot = idx[SLOT_W-1:0];
        end
      end
      OP_INSERT: begin
        idx = first_slot(e.key_id);
        if (idx + 1 < DEPTH) begin
          for (i = DEPTH - 1; i > idx + 1; i--) shadow_ids[i] = shadow_ids[i-1];
          shadow_ids[idx+1] = e.new_id;
          r.hit  = 1'b1;
          r.slot = 5'(idx + 1);
        end
      end
      OP_REMOVE: begin
        idx = first_slot(e.key_id);
        if (idx < DEPTH) begin
          for (i = idx; i + 1 < DEPTH; i++) shadow_ids[i] = shadow_ids[i+1];
          shadow_ids[DEPTH-1] = '0;
          r.hit  = 1'b1;
          r.slot = idx[SLOT_W-1:0];
        end
      end
      OP_UPDATE: begin
        idx = first_slot(e.key_id);
        if (idx < DEPTH) begin
          shadow_ids[idx] = e.new_id;
          r.hit  = 1'b1;
          r.slot = idx[SLOT_W-1:0];
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < DEPTH; i++) shadow_ids[i] = '0;
        r.hit = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic edit_row_t row(logic [OP_W-1:0] op, logic [ID_W-1:0] key_id,
                                    logic [ID_W-1:0] new_id, int rep, bit typed,
                                    logic hit, logic [SLOT_W-1:0] slot);
    edit_row_t e;
    e.op = op; e.key_id = key_id; e.new_id = new_id; e.rep = rep;
    e.typed = typed; e.hit = hit; e.slot = slot;
    return e;
  endfunction

  // Pick a random edit, mostly keyed on ids that sit in the table now so
  // that searches hit, and with enough appends and inserts to fill it
  function automatic in_t pick_edit();
    in_t e;
    int  r;
    r = $urandom_range(99);
    if (r < 33)      e.op = OP_APPEND;
    else if (r < 60) e.op = OP_INSERT;
    else if (r < 77) e.op = OP_REMOVE;
    else if (r < 92) e.op = OP_UPDATE;
    else if (r < 95) e.op = OP_CLEAR;
    else             e.op = OP_SPARE_5 + 3'($urandom_range(2));
    r = $urandom_range(99);
    if (r < 70)      e.key_id = shadow_ids[$urandom_range(DEPTH - 1)];
    else if (r < 78) e.key_id = shadow_ids[DEPTH-1];
    else if (r < 88) e.key_id = '0;
    else             e.key_id = 16'($urandom);
    r = $urandom_range(99);
    if (r < 85)      e.new_id = 16'($urandom_range(16'hFFFF, 1));
    else if (r < 90) e.new_id = '0;
    else             e.new_id = shadow_ids[$urandom_range(DEPTH - 1)];
    return e;
  endfunction

  // Drive one edit from a falling edge and hold it until its transfer;
  // return at the falling edge after the transfer with valid still high
  task automatic send_edit(in_t e, bit typed, out_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data      <= e;
    in_valid     <= 1'b1;
    typed_now    <= typed;
    typed_result <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(int count);
    out_t none;
    none = '0;
    repeat (count) send_edit(pick_edit(), 1'b0, none);
  endtask

  // Receiver: stall at random, at the rate of the current phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Predict on each input transfer, check on each output transfer
  always @(posedge clk) begin : check_p
    out_t want;
    out_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (in_data.op == OP_APPEND && first_slot('0) == DEPTH)
          n_full_appends++;
        if (in_data.op == OP_INSERT && first_slot(in_data.key_id) == DEPTH - 1)
          n_last_inserts++;
        want = edit_table(in_data);
        owed_results.push_back(typed_now ? typed_result : want);
        n_edits++;
        n_per_op[in_data.op]++;
        if (want.hit) n_hits++;
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (owed_results.size() == 0) begin
          $error("result with nothing owed: hit %0d slot %0d", got.hit, got.slot);
          n_fail++;
        end else begin
          want = owed_results.pop_front();
          n_checked++;
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            n_fail++;
          end
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            n_fail++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 STALL_LIMIT, owed_results.size());
        $display("** ordered_id_list_table_top: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    out_t want;
    in_t  e;
    for (int i = 0; i < DEPTH; i++) shadow_ids[i] = '0;
    foreach (n_per_op[i]) n_per_op[i] = 0;

    // Empty table first: every search misses
    directed_edits.push_back(row(OP_REMOVE, 16'h0005, 16'h0000, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_UPDATE, 16'h0007, 16'h0008, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_INSERT, 16'h0009, 16'h000A, 1, 1, 0, 0));
    // Build FFFF 1234 0001, then edit it
    directed_edits.push_back(row(OP_APPEND, 16'h0000, 16'hFFFF, 1, 1, 1, 0));
    directed_edits.push_back(row(OP_APPEND, 16'h0000, 16'h0001, 1, 1, 1, 1));
    directed_edits.push_back(row(OP_INSERT, 16'hFFFF, 16'h1234, 1, 1, 1, 1));
    // Update to the same value still reports a hit
    directed_edits.push_back(row(OP_UPDATE, 16'h1234, 16'h1234, 1, 1, 1, 1));
    directed_edits.push_back(row(OP_REMOVE, 16'hFFFF, 16'h0000, 1, 1, 1, 0));
    // Key zero finds the first empty slot
    directed_edits.push_back(row(OP_UPDATE, 16'h0000, 16'hABCD, 1, 1, 1, 2));
    directed_edits.push_back(row(OP_INSERT, 16'h0000, 16'h5555, 1, 1, 1, 4));
    directed_edits.push_back(row(OP_REMOVE, 16'h0000, 16'h0000, 1, 1, 1, 3));
    // New id zero is written as is and leaves a hole
    directed_edits.push_back(row(OP_APPEND, 16'h0000, 16'h0000, 1, 1, 1, 4));
    directed_edits.push_back(row(OP_UPDATE, 16'h0001, 16'h0000, 1, 1, 1, 1));
    directed_edits.push_back(row(OP_INSERT, 16'h5555, 16'h8000, 1, 0, 0, 0));
    // Spare op codes do nothing
    directed_edits.push_back(row(OP_SPARE_5, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_SPARE_6, 16'h1234, 16'h0001, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_SPARE_7, 16'hABCD, 16'h7FFF, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1, 1, 1, 0));
    // Fill every slot with 0100..011F, then hit the full-table cases
    directed_edits.push_back(row(OP_APPEND, 16'h0000, 16'h0100, DEPTH, 0, 0, 0));
    directed_edits.push_back(row(OP_APPEND, 16'h0000, 16'h7FFF, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_INSERT, 16'h011F, 16'h2222, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_INSERT, 16'h0100, 16'h8001, 1, 1, 1, 1));
    directed_edits.push_back(row(OP_REMOVE, 16'h011E, 16'h0000, 1, 1, 1, 31));
    directed_edits.push_back(row(OP_UPDATE, 16'h011F, 16'h0001, 1, 1, 0, 0));
    directed_edits.push_back(row(OP_REMOVE, 16'h0000, 16'h0000, 1, 1, 1, 31));
    directed_edits.push_back(row(OP_CLEAR, 16'h0000, 16'h0000, 1, 1, 1, 0));

    // Hold reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase one: sender rarely idles, receiver mostly stalls
    tx_idle_pct = 14;
    rx_idle_pct = 76;
    foreach (directed_edits[r]) begin
      for (int k = 0; k < directed_edits[r].rep; k++) begin
        e.op     = directed_edits[r].op;
        e.key_id = directed_edits[r].key_id;
        e.new_id = directed_edits[r].new_id + 16'(k);
        want.hit  = directed_edits[r].hit;
        want.slot = directed_edits[r].slot;
        send_edit(e, directed_edits[r].typed, want);
      end
    end
    send_random(RANDOM_EDITS);
    drain_results();

    // Phase two: the other way round
    tx_idle_pct = 76;
    rx_idle_pct = 14;
    send_random(RANDOM_EDITS);
    drain_results();

    // Phase three: full pressure on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(RANDOM_EDITS);
    drain_results();

    // Let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("edits: %0d (append %0d, insert %0d, remove %0d, update %0d, clear %0d, spare %0d)",
             n_edits, n_per_op[OP_APPEND], n_per_op[OP_INSERT], n_per_op[OP_REMOVE],
             n_per_op[OP_UPDATE], n_per_op[OP_CLEAR],
             n_per_op[OP_SPARE_5] + n_per_op[OP_SPARE_6] + n_per_op[OP_SPARE_7]);
    $display("results checked: %0d, hits %0d, appends to a full table %0d, %s %0d",
             n_checked, n_hits, n_full_appends, "inserts after the last slot",
             n_last_inserts);
    if (n_fail == 0) begin
      $display("** ordered_id_list_table_top: PASSED **");
    end else begin
      $display("** ordered_id_list_table_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
src/oilt_pkg.sv
src/oilt_ctrl.sv
src/oilt_dp.sv
src/ordered_id_list_table_top.sv
tb/tb.sv
